### src/ksh_pkg.sv
// Shared types and constants for the keyed signal-level histogram block.
`default_nettype none
package ksh_pkg;

  localparam logic [1:0] FN_ADD   = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  localparam logic [2:0] STS_OK     = 3'd0;
  localparam logic [2:0] STS_NEW    = 3'd1;
  localparam logic [2:0] STS_RANGE  = 3'd2;
  localparam logic [2:0] STS_FULL   = 3'd3;
  localparam logic [2:0] STS_ABSENT = 3'd4;

  localparam logic [15:0] SCALE_RST = 16'd1000;
  localparam int          QUO_BITS  = 16;
  // floor(x/5) == (x*205)>>10 for 0 <= x <= 128
  localparam logic [7:0]  RECIP5    = 8'd205;

  typedef struct packed {
    logic [1:0]         func;
    logic [47:0]        station_mac;
    logic signed [7:0]  signal_level;
    logic [5:0]         entry_index;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  entry_slot;
    logic [5:0]  entries_used;
    logic [47:0] entry_mac;
    logic [4:0]  bin_number;
    logic [31:0] raw_count;
    logic [15:0] normalized_count;
    logic        last;
  } out_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quo;
  } div_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRCH, ST_CLR, ST_CNT, ST_CNT_WR, ST_SUM,
    ST_BIN_RD, ST_BIN_MUL, ST_BIN_GO, ST_BIN_DIV, ST_EMIT
  } state_t;

endpackage
`default_nettype wire

### src/ksh_ram.sv
// Simple dual-port synchronous RAM with registered read.
`default_nettype none
module ksh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### src/ksh_div.sv
// Restoring divider, one quotient bit per cycle, 16-bit quotient.
`default_nettype none
module ksh_div
  import ksh_pkg::*;
#(
  parameter int NW = 48,
  parameter int DW = 38
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output div_sts_t           sts
);
  localparam int XW = ((NW > DW) ? NW : DW) + QUO_BITS;

  logic [XW-1:0]       rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [QUO_BITS-1:0] quo_r, quo_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic                done_r, done_nxt;
  logic                ge;

  assign ge = rem_r >= dsh_r;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = XW'(num);
      dsh_nxt = XW'(den) << (QUO_BITS - 1);
      cnt_nxt = 5'(QUO_BITS);
    end else if (cnt_r != 5'd0) begin
      if (ge) rem_nxt = rem_r - dsh_r;
      quo_nxt  = {quo_r[QUO_BITS-2:0], ge};
      dsh_nxt  = dsh_r >> 1;
      cnt_nxt  = cnt_r - 5'd1;
      done_nxt = (cnt_r == 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign sts.done = done_r;
  assign sts.quo  = quo_r;
endmodule
`default_nettype wire

### src/keyed_signal_level_histogram.sv
// Top level: per-key signal-level histogram table with search, count and read sequencer.
// Usage:
//   Input channel in_valid/in_data/in_stall carries one item (add, read or clear).
//   Result channel out_valid/out_data/out_stall carries result transfers; the last
//   result of an item has last set. Config channel cfg_valid/cfg_ready/cfg_data
//   writes norm_scale; cfg_ready is always high.
// Operation:
//   Add: key search walks the valid entries in the key RAM, one per cycle. A new key
//   is inserted and its BINS counters are zeroed before the level is counted.
//   Read: the entry's counters are summed, then per bin one RAM read, one multiply and
//   a 16-step divide; the divide is skipped when the entry total is 0.
//   One item is in flight at a time; the next is taken once the last result of the
//   current one sits in the output register.
// Reset clears the fill count and control state; no memory sweep is needed since
// counters are zeroed when a key is inserted. While out_stall is high on a valid transfer
// the output register holds it and the sequencer waits to emit the next result.
`default_nettype none
module keyed_signal_level_histogram
  import ksh_pkg::*;
#(
  parameter int ENTRIES    = 64,
  parameter int BINS       = 20,
  parameter int COUNT_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire in_t         in_data,
  output logic             in_stall,
  output logic             out_valid,
  output out_t             out_data,
  input  wire logic        out_stall,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  localparam int IW  = $clog2(ENTRIES);
  localparam int AW  = $clog2(ENTRIES * BINS);
  localparam int BCW = $clog2(BINS + 1);
  localparam int CB  = COUNT_BITS;
  localparam int TW  = CB + BCW;
  localparam int PW  = CB + 16;

  state_t         state_r, state_nxt;
  in_t            item_r, item_nxt;
  out_t           res_r, res_nxt, obuf_r, obuf_nxt;
  logic           ov_r, ov_nxt;
  logic [15:0]    scale_r;
  logic [IW-1:0]  used_r, used_nxt, srch_r, srch_nxt, cidx_r, cidx_nxt, slot_r, slot_nxt;
  logic           cvld_r, cvld_nxt, svld_r, svld_nxt, isnew_r, isnew_nxt;
  logic [BCW-1:0] bin_r, bin_nxt;
  logic [TW-1:0]  total_r, total_nxt;
  logic [CB-1:0]  cnt_r, cnt_nxt;
  logic [PW-1:0]  prod_r, prod_nxt;

  logic           in_acc, out_free, hit, issue, miss, full, rd_absent;
  logic [47:0]    key_q;
  logic [CB-1:0]  cnt_q, cnt_inc;
  logic [IW-1:0]  key_raddr;
  logic           key_we, cnt_we;
  logic [AW-1:0]  base, cnt_raddr, cnt_waddr;
  logic [31:0]    base_w;
  logic [7:0]     mag;
  logic [15:0]    mag_m;
  logic [4:0]     lbin;
  logic           inrange;
  logic           div_start;
  div_sts_t       div_sts;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !ov_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = obuf_r;

  assign hit       = cvld_r && (key_q == item_r.station_mac);
  assign issue     = !hit && (srch_r < used_r);
  assign miss      = !cvld_r && !(srch_r < used_r);
  assign full      = 32'(used_r) >= 32'(ENTRIES - 1);
  assign rd_absent = {26'd0, in_data.entry_index} >= 32'(used_r);

  // level bin: -level/5 truncating, levels 1..4 land in bin 0
  assign mag   = 8'd0 - item_r.signal_level;
  assign mag_m = 16'(mag) * 16'(RECIP5);
  always_comb begin
    lbin    = 5'd0;
    inrange = 1'b0;
    if (item_r.signal_level[7] || item_r.signal_level == 8'sd0) begin
      lbin    = mag_m[14:10];
      inrange = 32'(lbin) < 32'(BINS);
    end else if (item_r.signal_level < 8'sd5) begin
      inrange = 1'b1;
    end
  end

  assign base_w    = 32'(slot_r) * 32'(BINS);
  assign base      = base_w[AW-1:0];
  assign cnt_raddr = (state_r == ST_CNT) ? base + AW'(lbin) : base + AW'(bin_r);
  assign cnt_waddr = (state_r == ST_CLR) ? base + AW'(bin_r) : base + AW'(lbin);
  assign cnt_we    = (state_r == ST_CLR) || (state_r == ST_CNT_WR);
  assign cnt_inc   = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
  assign key_raddr = (state_r == ST_SRCH) ? srch_r : slot_r;
  assign key_we    = (state_r == ST_SRCH) && miss && !full;
  assign div_start = (state_r == ST_BIN_GO) && (total_r != '0);

  ksh_ram #(.WIDTH(48), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (used_r),
    .wdata (item_r.station_mac),
    .raddr (key_raddr),
    .rdata (key_q)
  );

  ksh_ram #(.WIDTH(CB), .DEPTH(ENTRIES * BINS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata ((state_r == ST_CLR) ? '0 : cnt_inc),
    .raddr (cnt_raddr),
    .rdata (cnt_q)
  );

  ksh_div #(.NW(PW), .DW(TW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (total_r),
    .sts   (div_sts)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (in_data.func == FN_ADD) state_nxt = ST_SRCH;
          else if (in_data.func == FN_READ) state_nxt = rd_absent ? ST_EMIT : ST_SUM;
          else if (in_data.func == FN_CLEAR) state_nxt = ST_EMIT;
          else state_nxt = ST_IDLE;
        end
      end
      ST_SRCH: begin
        if (hit) state_nxt = ST_CNT;
        else if (miss) state_nxt = full ? ST_EMIT : ST_CLR;
      end
      ST_CLR:     if (32'(bin_r) == 32'(BINS - 1)) state_nxt = ST_CNT;
      ST_CNT:     state_nxt = inrange ? ST_CNT_WR : ST_EMIT;
      ST_CNT_WR:  state_nxt = ST_EMIT;
      ST_SUM:     if (!svld_r && 32'(bin_r) == 32'(BINS)) state_nxt = ST_BIN_RD;
      ST_BIN_RD:  state_nxt = ST_BIN_MUL;
      ST_BIN_MUL: state_nxt = ST_BIN_GO;
      ST_BIN_GO:  state_nxt = (total_r == '0) ? ST_EMIT : ST_BIN_DIV;
      ST_BIN_DIV: if (div_sts.done) state_nxt = ST_EMIT;
      ST_EMIT:    if (out_free) state_nxt = res_r.last ? ST_IDLE : ST_BIN_RD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    item_nxt  = item_r;
    res_nxt   = res_r;
    obuf_nxt  = obuf_r;
    ov_nxt    = ov_r && out_stall;
    used_nxt  = used_r;
    srch_nxt  = srch_r;
    cidx_nxt  = cidx_r;
    cvld_nxt  = cvld_r;
    svld_nxt  = svld_r;
    slot_nxt  = slot_r;
    isnew_nxt = isnew_r;
    bin_nxt   = bin_r;
    total_nxt = total_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          item_nxt = in_data;
          srch_nxt = '0;
          cvld_nxt = 1'b0;
          svld_nxt = 1'b0;
          bin_nxt  = '0;
          total_nxt = '0;
          res_nxt  = '0;
          res_nxt.last = 1'b1;
          priority if (in_data.func == FN_READ) begin
            if (rd_absent) begin
              res_nxt.status     = STS_ABSENT;
              res_nxt.entry_slot = in_data.entry_index;
            end else begin
              slot_nxt = IW'(in_data.entry_index);
            end
          end else if (in_data.func == FN_CLEAR) begin
            used_nxt = '0;
          end else begin
          end
        end
      end
      ST_SRCH: begin
        if (hit) begin
          slot_nxt  = cidx_r;
          isnew_nxt = 1'b0;
        end else if (miss) begin
          if (full) begin
            res_nxt        = '0;
            res_nxt.status = STS_FULL;
            res_nxt.last   = 1'b1;
          end else begin
            slot_nxt  = used_r;
            used_nxt  = used_r + 1'b1;
            isnew_nxt = 1'b1;
            bin_nxt   = '0;
          end
        end else begin
          cvld_nxt = issue;
          cidx_nxt = srch_r;
          srch_nxt = srch_r + IW'(issue);
        end
      end
      ST_CLR: bin_nxt = bin_r + 1'b1;
      ST_CNT: begin
        res_nxt            = '0;
        res_nxt.status     = STS_RANGE;
        res_nxt.entry_slot = 6'(slot_r);
        res_nxt.entry_mac  = item_r.station_mac;
        res_nxt.last       = 1'b1;
      end
      ST_CNT_WR: begin
        res_nxt.status     = isnew_r ? STS_NEW : STS_OK;
        res_nxt.bin_number = lbin;
        res_nxt.raw_count  = 32'(cnt_inc);
      end
      ST_SUM: begin
        svld_nxt = (32'(bin_r) < 32'(BINS));
        if (svld_nxt) bin_nxt = bin_r + 1'b1;
        if (svld_r) total_nxt = total_r + TW'(cnt_q);
        if (!svld_r && 32'(bin_r) == 32'(BINS)) begin
          bin_nxt = '0;
          item_nxt.station_mac = key_q;
        end
      end
      ST_BIN_RD: ;
      ST_BIN_MUL: begin
        cnt_nxt  = cnt_q;
        prod_nxt = PW'(cnt_q) * PW'(scale_r);
      end
      ST_BIN_GO, ST_BIN_DIV: begin
        res_nxt                  = '0;
        res_nxt.status           = STS_OK;
        res_nxt.entry_slot       = 6'(slot_r);
        res_nxt.entry_mac        = item_r.station_mac;
        res_nxt.bin_number       = 5'(bin_r);
        res_nxt.raw_count        = 32'(cnt_r);
        res_nxt.normalized_count = (state_r == ST_BIN_DIV) ? div_sts.quo : 16'd0;
        res_nxt.last             = (32'(bin_r) == 32'(BINS - 1));
      end
      ST_EMIT: begin
        if (out_free) begin
          obuf_nxt              = res_r;
          obuf_nxt.entries_used = 6'(used_r);
          ov_nxt                = 1'b1;
          if (!res_r.last) bin_nxt = bin_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      used_r  <= '0;
      scale_r <= SCALE_RST;
      cvld_r  <= 1'b0;
      svld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      used_r  <= used_nxt;
      cvld_r  <= cvld_nxt;
      svld_r  <= svld_nxt;
      if (cfg_valid && cfg_ready) scale_r <= cfg_data;
    end
    item_r  <= item_nxt;
    res_r   <= res_nxt;
    obuf_r  <= obuf_nxt;
    srch_r  <= srch_nxt;
    cidx_r  <= cidx_nxt;
    slot_r  <= slot_nxt;
    isnew_r <= isnew_nxt;
    bin_r   <= bin_nxt;
    total_r <= total_nxt;
    cnt_r   <= cnt_nxt;
    prod_r  <= prod_nxt;
  end
endmodule
`default_nettype wire
